/* design/ezcvg_pkg.sv */
// Shared types, constants and helpers for the zero-crossing edge gate.
// No dependencies; every other design file refers to it by scoped names.
package ezcvg_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int EROW_W     = $clog2(MAX_HEIGHT);
    localparam int ROW_W      = $clog2(MAX_HEIGHT + 4);
    localparam int SIZE_W     = 11;
    localparam int THR_W      = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int LAP_AW     = COL_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_THRESH   = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_MIN    = 11'd5;
    localparam logic [SIZE_W-1:0] WIDTH_MAX   = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] HEIGHT_MAX  = SIZE_W'(MAX_HEIGHT);
    localparam logic [SIZE_W-1:0] SIZE_RESET  = 11'd512;
    localparam logic [THR_W-1:0]  THR_RESET   = 21'd2400;

    // floor(sum/25) for sum < 6400
    localparam logic [12:0] AVG_MUL   = 13'd5243;
    localparam int          AVG_SHIFT = 17;

    localparam logic [7:0] PIX_WHITE = 8'd255;
    localparam logic [7:0] PIX_EDGE  = 8'd0;

    typedef struct packed {
        logic              take;
        logic [1:0]        bank;
        logic [COL_W-1:0]  col;
        logic              lap_we;
        logic              lap_slot;
        logic [COL_W-1:0]  lap_col;
        logic              emit;
        logic              interior;
        logic              right_en;
        logic              lower_en;
        logic [EROW_W-1:0] e_row;
        logic [COL_W-1:0]  e_col;
        logic              last;
    } ctrl_t;

    typedef struct packed {
        logic [7:0]  mx;
        logic [7:0]  mn;
        logic [7:0]  mid;
        logic [10:0] sum;
        logic [18:0] sq;
    } colstat_t;

    function automatic logic [15:0] sq8(input logic [7:0] v);
        return 16'(v) * 16'(v);
    endfunction

    // stored Laplacian is 9-bit; bit 8 reads as the sign
    function automatic logic positive9(input logic [8:0] v);
        return (v != 9'd0) && !v[8];
    endfunction

endpackage

/* design/ezcvg_ctrl.sv */
// Configuration registers, frame and emit position counters.
// Produces the per-request control word at accept time. Uses ezcvg_pkg.
module ezcvg_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ezcvg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ezcvg_pkg::THR_W-1:0]         cfg_data,
    input  logic                                accept,
    input  logic                                op,
    output ezcvg_pkg::ctrl_t                    ctrl,
    output logic [ezcvg_pkg::THR_W-1:0]         threshold
);

    localparam logic [ezcvg_pkg::ROW_W-1:0] ROW3 = ezcvg_pkg::ROW_W'(3);
    localparam logic [ezcvg_pkg::ROW_W-1:0] ROW4 = ezcvg_pkg::ROW_W'(4);
    localparam logic [ezcvg_pkg::COL_W-1:0] COL2 = ezcvg_pkg::COL_W'(2);
    localparam logic [ezcvg_pkg::COL_W-1:0] COL4 = ezcvg_pkg::COL_W'(4);

    logic [ezcvg_pkg::SIZE_W-1:0] width_reg, height_reg;
    logic [ezcvg_pkg::THR_W-1:0]  thr_reg;
    logic [ezcvg_pkg::ROW_W-1:0]  in_row_reg;
    logic [ezcvg_pkg::COL_W-1:0]  in_col_reg;
    logic [ezcvg_pkg::EROW_W-1:0] e_row_reg;
    logic [ezcvg_pkg::COL_W-1:0]  e_col_reg;

    logic in_frame, ignored, take, emit, last_pos, col_wrap, ecol_wrap;
    logic [11:0] r12, c12, w12, h12;

    function automatic logic [ezcvg_pkg::SIZE_W-1:0] clamp_size(
        input logic [ezcvg_pkg::SIZE_W-1:0] v,
        input logic [ezcvg_pkg::SIZE_W-1:0] hi);
        if (v < ezcvg_pkg::SIZE_MIN) return ezcvg_pkg::SIZE_MIN;
        if (v > hi) return hi;
        return v;
    endfunction

    assign cfg_ready = 1'b1;
    assign threshold = thr_reg;

    always_comb begin
        r12 = 12'(e_row_reg);
        c12 = 12'(e_col_reg);
        w12 = 12'(width_reg);
        h12 = 12'(height_reg);
        in_frame  = 12'(in_row_reg) < h12;
        ignored   = in_frame && op;
        take      = in_frame && !op;
        emit      = !ignored && ((in_row_reg > ROW3) ||
                    ((in_row_reg == ROW3) && (in_col_reg >= COL2)));
        last_pos  = (r12 == h12 - 12'd1) && (c12 == w12 - 12'd1);
        col_wrap  = (12'(in_col_reg) + 12'd1) == w12;
        ecol_wrap = (c12 + 12'd1) == w12;

        ctrl.take     = take;
        ctrl.bank     = in_row_reg[1:0];
        ctrl.col      = in_col_reg;
        ctrl.lap_we   = take && (in_row_reg >= ROW4) && (in_col_reg >= COL4);
        ctrl.lap_slot = in_row_reg[0];
        ctrl.lap_col  = in_col_reg - COL2;
        ctrl.emit     = emit;
        ctrl.interior = (r12 >= 12'd2) && (r12 + 12'd3 <= h12) &&
                        (c12 >= 12'd2) && (c12 + 12'd3 <= w12);
        ctrl.right_en = c12 + 12'd4 <= w12;
        ctrl.lower_en = r12 + 12'd4 <= h12;
        ctrl.e_row    = e_row_reg;
        ctrl.e_col    = e_col_reg;
        ctrl.last     = emit && last_pos;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= ezcvg_pkg::SIZE_RESET;
            height_reg <= ezcvg_pkg::SIZE_RESET;
            thr_reg    <= ezcvg_pkg::THR_RESET;
            in_row_reg <= '0;
            in_col_reg <= '0;
            e_row_reg  <= '0;
            e_col_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                ezcvg_pkg::CFG_IMAGE_WIDTH: begin
                    width_reg  <= clamp_size(cfg_data[ezcvg_pkg::SIZE_W-1:0],
                                             ezcvg_pkg::WIDTH_MAX);
                    in_row_reg <= '0;
                    in_col_reg <= '0;
                    e_row_reg  <= '0;
                    e_col_reg  <= '0;
                end
                ezcvg_pkg::CFG_IMAGE_HEIGHT: begin
                    height_reg <= clamp_size(cfg_data[ezcvg_pkg::SIZE_W-1:0],
                                             ezcvg_pkg::HEIGHT_MAX);
                    in_row_reg <= '0;
                    in_col_reg <= '0;
                    e_row_reg  <= '0;
                    e_col_reg  <= '0;
                end
                ezcvg_pkg::CFG_DEV_THRESH: begin
                    thr_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end else if (accept && !ignored) begin
            if (emit && last_pos) begin
                in_row_reg <= '0;
                in_col_reg <= '0;
                e_row_reg  <= '0;
                e_col_reg  <= '0;
            end else begin
                if (emit) begin
                    if (ecol_wrap) begin
                        e_col_reg <= '0;
                        e_row_reg <= e_row_reg + 1'b1;
                    end else begin
                        e_col_reg <= e_col_reg + 1'b1;
                    end
                end
                if (col_wrap) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + 1'b1;
                end else begin
                    in_col_reg <= in_col_reg + 1'b1;
                end
            end
        end
    end

endmodule

/* design/ezcvg_line_buf.sv */
// Four pixel line buffers, column gathering and per-column statistics,
// plus the five-column window shift register. Uses ezcvg_pkg.
module ezcvg_line_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 ld1,
    input  logic                 ld2,
    input  ezcvg_pkg::ctrl_t     c0,
    input  ezcvg_pkg::ctrl_t     c1,
    input  logic [7:0]           pixel,
    output ezcvg_pkg::colstat_t  colwin [5]
);

    logic [7:0] rd_reg [4];
    logic [7:0] pix_reg;
    logic [7:0] col_pix [5];
    ezcvg_pkg::colstat_t col_new;
    ezcvg_pkg::colstat_t colwin_reg [5];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [7:0] mem [ezcvg_pkg::MAX_WIDTH];
        always_ff @(posedge aclk) begin
            if (ld1) begin
                if (c0.take && (c0.bank == 2'(b))) begin
                    mem[c0.col] <= pixel;
                end
                rd_reg[b] <= mem[c0.col];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1) begin
            pix_reg <= pixel;
        end
    end

    always_comb begin
        for (int rr = 0; rr < 4; rr++) begin
            col_pix[rr] = rd_reg[2'(c1.bank + 2'(rr))];
        end
        col_pix[4] = pix_reg;
        col_new.mx  = col_pix[0];
        col_new.mn  = col_pix[0];
        col_new.sum = 11'(col_pix[0]);
        col_new.sq  = 19'(ezcvg_pkg::sq8(col_pix[0]));
        for (int k = 1; k < 5; k++) begin
            if (col_pix[k] > col_new.mx) col_new.mx = col_pix[k];
            if (col_pix[k] < col_new.mn) col_new.mn = col_pix[k];
            col_new.sum = col_new.sum + 11'(col_pix[k]);
            col_new.sq  = col_new.sq + 19'(ezcvg_pkg::sq8(col_pix[k]));
        end
        col_new.mid = col_pix[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 5; k++) colwin_reg[k] <= '0;
        end else if (ld2 && c1.take) begin
            for (int k = 0; k < 4; k++) colwin_reg[k] <= colwin_reg[k+1];
            colwin_reg[4] <= col_new;
        end
    end

    assign colwin = colwin_reg;

endmodule

/* design/ezcvg_stats.sv */
// Window statistics pipeline: max/min/sum/sum of squares, floor mean,
// Laplacian, squared deviation sum and threshold flag. Uses ezcvg_pkg.
module ezcvg_stats (
    input  logic                         aclk,
    input  logic                         ld3,
    input  logic                         ld4,
    input  logic                         ld5,
    input  logic                         ld6,
    input  ezcvg_pkg::colstat_t          colwin [5],
    input  logic [ezcvg_pkg::THR_W-1:0]  threshold,
    output logic [9:0]                   lap6,
    output logic                         flag6
);

    logic [7:0]  mx3_reg, mn3_reg, ctr3_reg;
    logic [12:0] sum3_reg, sum4_reg;
    logic [20:0] sq3_reg, sq4_reg, sq5_reg;
    logic [7:0]  avg4_reg;
    logic [9:0]  lap4_reg, lap5_reg, lap6_reg;
    logic [20:0] p1_reg;
    logic [15:0] p2_reg;
    logic        flag6_reg;

    logic [7:0]  mx_c, mn_c;
    logic [12:0] sum_c;
    logic [20:0] sq_c;
    logic [25:0] avg_prod;
    logic [23:0] dev_c;

    always_comb begin
        mx_c  = colwin[0].mx;
        mn_c  = colwin[0].mn;
        sum_c = 13'(colwin[0].sum);
        sq_c  = 21'(colwin[0].sq);
        for (int k = 1; k < 5; k++) begin
            if (colwin[k].mx > mx_c) mx_c = colwin[k].mx;
            if (colwin[k].mn < mn_c) mn_c = colwin[k].mn;
            sum_c = sum_c + 13'(colwin[k].sum);
            sq_c  = sq_c + 21'(colwin[k].sq);
        end
        avg_prod = 26'(sum3_reg) * 26'(ezcvg_pkg::AVG_MUL);
        dev_c = 24'(sq5_reg) + 24'(p2_reg) * 24'd25 - {2'b0, p1_reg, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (ld3) begin
            mx3_reg  <= mx_c;
            mn3_reg  <= mn_c;
            sum3_reg <= sum_c;
            sq3_reg  <= sq_c;
            ctr3_reg <= colwin[2].mid;
        end
        if (ld4) begin
            avg4_reg <= avg_prod[ezcvg_pkg::AVG_SHIFT +: 8];
            lap4_reg <= 10'(mx3_reg) + 10'(mn3_reg) - {1'b0, ctr3_reg, 1'b0};
            sum4_reg <= sum3_reg;
            sq4_reg  <= sq3_reg;
        end
        if (ld5) begin
            p1_reg   <= 21'(avg4_reg) * 21'(sum4_reg);
            p2_reg   <= 16'(avg4_reg) * 16'(avg4_reg);
            lap5_reg <= lap4_reg;
            sq5_reg  <= sq4_reg;
        end
        if (ld6) begin
            lap6_reg  <= lap5_reg;
            flag6_reg <= lap5_reg[9] && (dev_c >= 24'(threshold));
        end
    end

    assign lap6  = lap6_reg;
    assign flag6 = flag6_reg;

endmodule

/* design/ezcvg_decide.sv */
// Laplacian line store and zero-crossing decision; holds the result payload.
// Uses ezcvg_pkg.
module ezcvg_decide (
    input  logic              aclk,
    input  logic              ld6,
    input  logic              ld7,
    input  ezcvg_pkg::ctrl_t  c5,
    input  ezcvg_pkg::ctrl_t  c6,
    input  logic [9:0]        lap6,
    input  logic              flag6,
    output logic              out_valid,
    output logic [7:0]        out_value,
    output logic [9:0]        out_row,
    output logic [9:0]        out_col,
    output logic              out_last
);

    logic [9:0] lap_mem [2 * ezcvg_pkg::MAX_WIDTH];
    logic [9:0] self_rd_reg, right_rd_reg;
    logic       valid_reg, last_reg;
    logic [7:0] value_reg;
    logic [9:0] row_reg, col_reg;
    logic       hit;

    always_ff @(posedge aclk) begin
        if (ld7 && c6.lap_we) begin
            lap_mem[{c6.lap_slot, c6.lap_col}] <= {flag6, lap6[8:0]};
        end
        if (ld6) begin
            self_rd_reg  <= lap_mem[{c5.e_row[0], c5.e_col}];
            right_rd_reg <= lap_mem[{c5.e_row[0], c5.e_col + 1'b1}];
        end
    end

    always_comb begin
        hit = c6.interior && self_rd_reg[9] &&
              ((c6.right_en && ezcvg_pkg::positive9(right_rd_reg[8:0])) ||
               (c6.lower_en && ezcvg_pkg::positive9(lap6[8:0])));
    end

    always_ff @(posedge aclk) begin
        if (ld7) begin
            valid_reg <= c6.emit;
            value_reg <= !c6.emit ? 8'd0 :
                         (hit ? ezcvg_pkg::PIX_EDGE : ezcvg_pkg::PIX_WHITE);
            row_reg   <= c6.emit ? 10'(c6.e_row) : 10'd0;
            col_reg   <= c6.emit ? 10'(c6.e_col) : 10'd0;
            last_reg  <= c6.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_value = value_reg;
    assign out_row   = row_reg;
    assign out_col   = col_reg;
    assign out_last  = last_reg;

endmodule

/* design/edge_zero_crossing_variance_gate.sv */
// Edge detector top level: handshake, pipeline valids and control delay line.
// Uses ezcvg_pkg, ezcvg_ctrl, ezcvg_line_buf, ezcvg_stats, ezcvg_decide.
//
// Takes one request (pixel or drain tick) per clock while s_ready is high and
// returns exactly one result per request, in order. Sustained rate is one
// request per cycle when the output is not stalled; the seven-stage pipeline
// (line-buffer read, column stats, window stats, mean, products, deviation,
// decision) fills stage bubbles while a result waits to be taken, so s_ready
// drops only when every stage is full and m_ready is low. Results lag the
// pixel stream by 3*width+2 requests; drain ticks flush the tail of the frame.
// Configuration writes are taken at any time but are meant for an idle block;
// a size write restarts the frame position.
module edge_zero_crossing_variance_gate (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_operation,
    input  logic [7:0]                        s_pixel,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_out_valid,
    output logic [7:0]                        m_out_value,
    output logic [9:0]                        m_out_row,
    output logic [9:0]                        m_out_col,
    output logic                              m_out_last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ezcvg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ezcvg_pkg::THR_W-1:0]       cfg_data
);

    logic [6:1] v_reg;
    logic       mv_reg;
    logic [7:1] rdy;
    logic [7:1] ld;
    ezcvg_pkg::ctrl_t c0;
    ezcvg_pkg::ctrl_t c_reg [1:6];
    ezcvg_pkg::colstat_t colwin [5];
    logic [ezcvg_pkg::THR_W-1:0] threshold;
    logic [9:0] lap6;
    logic       flag6;

    always_comb begin
        rdy[7] = !mv_reg || m_ready;
        for (int k = 6; k >= 1; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        ld[1] = s_valid && rdy[1];
        for (int k = 2; k <= 7; k++) begin
            ld[k] = v_reg[k-1] && rdy[k];
        end
    end

    assign s_ready = rdy[1];
    assign m_valid = mv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg  <= '0;
            mv_reg <= 1'b0;
        end else begin
            for (int k = 1; k <= 6; k++) begin
                if (ld[k]) begin
                    v_reg[k] <= 1'b1;
                end else if (rdy[k+1]) begin
                    v_reg[k] <= 1'b0;
                end
            end
            if (ld[7]) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[1]) c_reg[1] <= c0;
        for (int k = 2; k <= 6; k++) begin
            if (ld[k]) c_reg[k] <= c_reg[k-1];
        end
    end

    ezcvg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (ld[1]),
        .op        (s_operation),
        .ctrl      (c0),
        .threshold (threshold)
    );

    ezcvg_line_buf u_line_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ld1     (ld[1]),
        .ld2     (ld[2]),
        .c0      (c0),
        .c1      (c_reg[1]),
        .pixel   (s_pixel),
        .colwin  (colwin)
    );

    ezcvg_stats u_stats (
        .aclk      (aclk),
        .ld3       (ld[3]),
        .ld4       (ld[4]),
        .ld5       (ld[5]),
        .ld6       (ld[6]),
        .colwin    (colwin),
        .threshold (threshold),
        .lap6      (lap6),
        .flag6     (flag6)
    );

    ezcvg_decide u_decide (
        .aclk      (aclk),
        .ld6       (ld[6]),
        .ld7       (ld[7]),
        .c5        (c_reg[5]),
        .c6        (c_reg[6]),
        .lap6      (lap6),
        .flag6     (flag6),
        .out_valid (m_out_valid),
        .out_value (m_out_value),
        .out_row   (m_out_row),
        .out_col   (m_out_col),
        .out_last  (m_out_last)
    );

endmodule
